@@ hw/rtl/spr_pkg.sv @@
// shared types, codes and constants of the service port range classifier
package spr_pkg;

  localparam int unsigned RULES_DEF = 64;

  localparam int unsigned SVC_W   = 10;
  localparam int unsigned PROTO_W = 8;
  localparam int unsigned PORT_W  = 16;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned IN_DW   = 120;
  localparam int unsigned OUT_DW  = 16;

  localparam logic [PROTO_W-1:0] PROTO_ICMP = 8'd1;
  localparam logic [PROTO_W-1:0] PROTO_TCP  = 8'd6;
  localparam logic [PROTO_W-1:0] PROTO_UDP  = 8'd17;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_APPENDED = 3'd0,
    ST_FULL     = 3'd1,
    ST_MATCH    = 3'd2,
    ST_NOMATCH  = 3'd3,
    ST_CLEARED  = 3'd4
  } status_t;

  typedef struct packed {
    logic [SVC_W-1:0]   svc;
    logic [PROTO_W-1:0] proto;
    logic [PORT_W-1:0]  dst_lo;
    logic [PORT_W-1:0]  dst_hi;
    logic [PORT_W-1:0]  src_lo;
    logic [PORT_W-1:0]  src_hi;
  } rule_t;

  // lookup token walking the cell row
  typedef struct packed {
    logic               vld;
    logic [PROTO_W-1:0] proto;
    logic [PORT_W-1:0]  psrc;
    logic [PORT_W-1:0]  pdst;
    logic               hit;
    logic [SVC_W-1:0]   svc;
  } token_t;

endpackage

@@ hw/rtl/service_port_range_classifier.sv @@
// top level of the service port range classifier: rule row, fill count, result register
//
//  channel | dir | tuser        | tdata
//  in_     | in  | mode         | service_id, protocol, rule ports, packet ports
//  out_    | out | status       | matched_service
//
// append, clear and unused mode codes load the result register in the cycle after they
// are accepted; a lookup walks the row of RULES cells, one cell per cycle, then its result
// passes through the pending register into the result register. one item is in work at a
// time; an item is accepted only while the result register is empty or being read. reset
// empties the table at once (fill count to zero); rule contents are not cleared. a stalled
// output holds the finished lookup result until out_tready.
module service_port_range_classifier #(
  parameter int unsigned RULES = spr_pkg::RULES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // service_id, protocol, rule_dst_low, rule_dst_high, rule_src_low,
  // rule_src_high, packet_src, packet_dst, zero fill
  input  logic [spr_pkg::IN_DW-1:0]   in_tdata,
  // mode
  input  logic [spr_pkg::MODE_W-1:0]  in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // matched_service, zero fill
  output logic [spr_pkg::OUT_DW-1:0]  out_tdata,
  // status
  output logic [spr_pkg::STAT_W-1:0]  out_tuser
);
  import spr_pkg::*;

  localparam int unsigned FILL_W = $clog2(RULES + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              acc;
  mode_t             mode;
  rule_t             wr_rule;
  token_t            tok [0:RULES];
  logic [RULES-1:0]  tok_vld;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [SVC_W-1:0]  out_svc_r, out_svc_nxt;
  status_t           pend_status_r, pend_status_nxt;
  logic [SVC_W-1:0]  pend_svc_r, pend_svc_nxt;
  logic              out_free;
  logic              full;

  assign mode     = mode_t'(in_tuser);
  assign out_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign acc      = in_tvalid && in_tready;
  assign full     = (fill_r == FILL_W'(RULES));

  assign wr_rule.svc    = in_tdata[9:0];
  assign wr_rule.proto  = in_tdata[17:10];
  assign wr_rule.dst_lo = in_tdata[33:18];
  assign wr_rule.dst_hi = in_tdata[49:34];
  assign wr_rule.src_lo = in_tdata[65:50];
  assign wr_rule.src_hi = in_tdata[81:66];

  always_comb begin
    tok[0].vld   = acc && (mode == MODE_LOOKUP);
    tok[0].proto = in_tdata[17:10];
    tok[0].psrc  = in_tdata[97:82];
    tok[0].pdst  = in_tdata[113:98];
    tok[0].hit   = 1'b0;
    tok[0].svc   = '0;
  end

  for (genvar i = 0; i < RULES; i++) begin : g_cell
    spr_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr_en   (acc && (mode == MODE_APPEND) && (fill_r == FILL_W'(i))),
      .wr_rule (wr_rule),
      .live    (fill_r > FILL_W'(i)),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
    assign tok_vld[i] = tok[i+1].vld;
  end

  always_comb begin
    fill_nxt        = fill_r;
    state_nxt       = state_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_status_nxt  = out_status_r;
    out_svc_nxt     = out_svc_r;
    pend_status_nxt = pend_status_r;
    pend_svc_nxt    = pend_svc_r;
    if (acc) begin
      unique case (mode)
        MODE_APPEND: begin
          out_valid_nxt  = 1'b1;
          out_svc_nxt    = '0;
          if (full) begin
            out_status_nxt = ST_FULL;
          end else begin
            out_status_nxt = ST_APPENDED;
            fill_nxt       = fill_r + FILL_W'(1);
          end
        end
        MODE_LOOKUP: begin
          state_nxt = S_SCAN;
        end
        MODE_CLEAR: begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_CLEARED;
          out_svc_nxt    = '0;
          fill_nxt       = '0;
        end
        default: begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_NOMATCH;
          out_svc_nxt    = '0;
        end
      endcase
    end
    if (state_r == S_SCAN && tok[RULES].vld) begin
      pend_status_nxt = tok[RULES].hit ? ST_MATCH : ST_NOMATCH;
      pend_svc_nxt    = tok[RULES].hit ? tok[RULES].svc : '0;
      state_nxt       = S_DONE;
    end
    if (state_r == S_DONE && out_free) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = pend_status_r;
      out_svc_nxt    = pend_svc_r;
      state_nxt      = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r  <= out_status_nxt;
    out_svc_r     <= out_svc_nxt;
    pend_status_r <= pend_status_nxt;
    pend_svc_r    <= pend_svc_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(OUT_DW - SVC_W){1'b0}}, out_svc_r};

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(RULES))
    else $error("rule fill count beyond table size");

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(tok_vld) <= 1)
    else $error("more than one lookup in the cell row");

  a_token_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tok[RULES].vld |-> state_r == S_SCAN)
    else $error("lookup left the row outside a scan");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !acc)
    else $error("item accepted during a scan");

endmodule

@@ hw/rtl/spr_cell.sv @@
// one rule cell: holds a rule and checks the passing lookup token against it
module spr_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  spr_pkg::rule_t wr_rule,
  input  logic           live,
  input  spr_pkg::token_t tok_in,
  output spr_pkg::token_t tok_out
);
  import spr_pkg::*;

  rule_t  rule_r;
  token_t tok_r;
  token_t tok_nxt;
  logic   dst_ok;
  logic   src_ok;
  logic   match;

  // high bound of zero means exact port
  function automatic logic port_fits(input logic [PORT_W-1:0] port,
                                     input logic [PORT_W-1:0] lo,
                                     input logic [PORT_W-1:0] hi);
    logic r;
    if (hi == '0) r = (port == lo);
    else          r = (port >= lo) && (port <= hi);
    return r;
  endfunction

  always_comb begin
    dst_ok = port_fits(tok_in.pdst, rule_r.dst_lo, rule_r.dst_hi);
    src_ok = port_fits(tok_in.psrc, rule_r.src_lo, rule_r.src_hi);
    match  = 1'b0;
    if (rule_r.proto == tok_in.proto) begin
      if (tok_in.proto == PROTO_ICMP) begin
        match = (rule_r.dst_lo == tok_in.psrc) && (rule_r.dst_hi == tok_in.pdst);
      end else if (tok_in.proto == PROTO_TCP || tok_in.proto == PROTO_UDP) begin
        match = dst_ok && src_ok;
      end else begin
        match = 1'b1;
      end
    end
    tok_nxt = tok_in;
    // first match wins: an earlier hit passes through untouched
    if (!tok_in.hit && live && match) begin
      tok_nxt.hit = 1'b1;
      tok_nxt.svc = rule_r.svc;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rule_r <= wr_rule;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r.vld <= tok_nxt.vld;
    end
    tok_r.proto <= tok_nxt.proto;
    tok_r.psrc  <= tok_nxt.psrc;
    tok_r.pdst  <= tok_nxt.pdst;
    tok_r.hit   <= tok_nxt.hit;
    tok_r.svc   <= tok_nxt.svc;
  end

  assign tok_out = tok_r;

endmodule

@@ verif/service_port_range_classifier_test.sv @@
// self-checking stream testbench of the service port range classifier
module service_port_range_classifier_test;
  timeunit 1ns;
  timeprecision 1ps;

  import spr_pkg::*;

  localparam int unsigned N_RULES    = RULES_DEF;
  localparam int unsigned QUIET_MAX  = 3000;
  localparam int unsigned HOLD_LEN   = 400;
  localparam int unsigned PHASE_ITEMS = 600;
  localparam int unsigned ITEM_W     = 2 + SVC_W + PROTO_W + 6 * PORT_W;

  typedef struct packed {
    mode_t              mode;
    logic [SVC_W-1:0]   svc;
    logic [PROTO_W-1:0] proto;
    logic [PORT_W-1:0]  dst_lo;
    logic [PORT_W-1:0]  dst_hi;
    logic [PORT_W-1:0]  src_lo;
    logic [PORT_W-1:0]  src_hi;
    logic [PORT_W-1:0]  psrc;
    logic [PORT_W-1:0]  pdst;
  } cls_item_t;

  typedef struct packed {
    status_t          st;
    logic [SVC_W-1:0] svc;
  } verdict_t;

  typedef struct {
    cls_item_t        it;
    bit               chk;
    status_t          st;
    logic [SVC_W-1:0] svc;
  } dir_row_t;

  logic                clk;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [IN_DW-1:0]    in_tdata   = '0;
  logic [MODE_W-1:0]   in_tuser   = MODE_APPEND;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_DW-1:0]   out_tdata;
  logic [STAT_W-1:0]   out_tuser;

  // predictor copy of the rule table
  rule_t               rule_tab [N_RULES];
  int unsigned         rule_cnt = 0;
  verdict_t            pending_verdicts [$];
  verdict_t            want;

  int unsigned         errs = 0;
  int unsigned         send_idle = 18;
  int unsigned         recv_idle = 82;
  bit                  hold_req = 1'b0;
  bit                  hold_done = 1'b0;
  int unsigned         hold_cnt = 0;
  int unsigned         quiet = 0;

  dir_row_t            dir_tab [25];

  service_port_range_classifier #(.RULES(N_RULES)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit port_fits(logic [PORT_W-1:0] port, logic [PORT_W-1:0] lo,
                                   logic [PORT_W-1:0] hi);
    if (hi == '0) return port == lo;
    return port >= lo && port <= hi;
  endfunction

  function automatic bit rule_hits(rule_t r, cls_item_t it);
    if (r.proto != it.proto) return 1'b0;
    if (it.proto == PROTO_ICMP) return r.dst_lo == it.psrc && r.dst_hi == it.pdst;
    if (it.proto == PROTO_TCP || it.proto == PROTO_UDP)
      return port_fits(it.pdst, r.dst_lo, r.dst_hi) && port_fits(it.psrc, r.src_lo, r.src_hi);
    return 1'b1;
  endfunction

  // applies one item to the predictor table and returns its verdict
  function automatic verdict_t classify(cls_item_t it);
    verdict_t v;
    int unsigned i;
    v.st  = ST_NOMATCH;
    v.svc = '0;
    case (it.mode)
      MODE_APPEND: begin
        if (rule_cnt < N_RULES) begin
          rule_tab[rule_cnt] = '{it.svc, it.proto, it.dst_lo, it.dst_hi, it.src_lo, it.src_hi};
          rule_cnt++;
          v.st = ST_APPENDED;
        end else begin
          v.st = ST_FULL;
        end
      end
      MODE_LOOKUP: begin
        for (i = 0; i < rule_cnt && v.st != ST_MATCH; i++) begin
          if (rule_hits(rule_tab[i], it)) begin
            v.st  = ST_MATCH;
            v.svc = rule_tab[i].svc;
          end
        end
      end
      MODE_CLEAR: begin
        rule_cnt = 0;
        v.st = ST_CLEARED;
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic cls_item_t rand_bits();
    logic [127:0] raw;
    raw = {$urandom(), $urandom(), $urandom(), $urandom()};
    return raw[ITEM_W-1:0];
  endfunction

  function automatic void shape_bounds(inout logic [PORT_W-1:0] lo, inout logic [PORT_W-1:0] hi);
    case ($urandom_range(0, 9))
      0, 1: hi = '0;
      2: begin
        lo = '0;
        hi = '1;
      end
      3: hi = '1;
      4: if (lo > 1) hi = PORT_W'($urandom_range(1, lo - 1));  // inverted range
      default: hi = (lo > 16'hFFFF - 600) ? 16'hFFFF : PORT_W'(lo + $urandom_range(0, 600));
    endcase
  endfunction

  function automatic cls_item_t rand_rule();
    cls_item_t x;
    x = rand_bits();
    x.mode = MODE_APPEND;
    case ($urandom_range(0, 9))
      0, 1, 2: x.proto = PROTO_TCP;
      3, 4, 5: x.proto = PROTO_UDP;
      6, 7: x.proto = PROTO_ICMP;
      default: ;
    endcase
    shape_bounds(x.dst_lo, x.dst_hi);
    shape_bounds(x.src_lo, x.src_hi);
    if (x.proto == PROTO_ICMP && $urandom_range(0, 1) == 0) begin
      x.dst_lo = PORT_W'($urandom_range(0, 18));
      x.dst_hi = PORT_W'($urandom_range(0, 15));
    end
    return x;
  endfunction

  function automatic logic [PORT_W-1:0] pick_port(logic [PORT_W-1:0] lo, logic [PORT_W-1:0] hi);
    if (hi == '0) return lo;
    if (lo <= hi) return PORT_W'($urandom_range(lo, hi));
    return PORT_W'($urandom());
  endfunction

  // mostly packets aimed at a held rule, some of them nudged off it
  function automatic cls_item_t rand_lookup();
    cls_item_t x;
    rule_t r;
    x = rand_bits();
    x.mode = MODE_LOOKUP;
    if (rule_cnt > 0 && $urandom_range(0, 3) != 0) begin
      r = rule_tab[$urandom_range(0, rule_cnt - 1)];
      x.proto = r.proto;
      if (r.proto == PROTO_ICMP) begin
        x.psrc = r.dst_lo;
        x.pdst = r.dst_hi;
      end else if (r.proto == PROTO_TCP || r.proto == PROTO_UDP) begin
        x.pdst = pick_port(r.dst_lo, r.dst_hi);
        x.psrc = pick_port(r.src_lo, r.src_hi);
      end
      case ($urandom_range(0, 9))
        0: x.psrc ^= 16'd1 << $urandom_range(0, 15);
        1: x.pdst ^= 16'd1 << $urandom_range(0, 15);
        2: x.proto = PROTO_W'($urandom());
        default: ;
      endcase
    end else if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 2))
        0: x.proto = PROTO_TCP;
        1: x.proto = PROTO_UDP;
        default: x.proto = PROTO_ICMP;
      endcase
    end
    return x;
  endfunction

  task automatic send_item(cls_item_t it, bit chk = 1'b0, verdict_t typed = '0);
    verdict_t v;
    while ($urandom_range(0, 99) < send_idle) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= it.mode;
    in_tdata  <= {{(IN_DW - ITEM_W + 2){1'b0}}, it.pdst, it.psrc, it.src_hi, it.src_lo,
                  it.dst_hi, it.dst_lo, it.proto, it.svc};
    do @(posedge clk); while (!in_tready);
    v = classify(it);
    pending_verdicts.push_back(chk ? typed : v);
  endtask

  task automatic run_random(int unsigned n_items);
    int unsigned sent;
    int unsigned k;
    int unsigned j;
    int unsigned pick;
    cls_item_t x;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        x = rand_bits();
        x.mode = MODE_CLEAR;
        send_item(x);
        sent++;
      end else if (pick < 9) begin
        // noise: any mode code with raw fields
        x = rand_bits();
        x.mode = mode_t'($urandom_range(0, 3));
        send_item(x);
        sent++;
      end else if (pick < 32) begin
        if ($urandom_range(0, 9) == 0)
          k = N_RULES - rule_cnt + $urandom_range(0, 4);
        else
          k = $urandom_range(1, 6);
        for (j = 0; j < k; j++) send_item(rand_rule());
        sent += k;
      end else begin
        k = $urandom_range(1, 4);
        for (j = 0; j < k; j++) send_item(rand_lookup());
        sent += k;
      end
    end
  endtask

  // receiver side, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_cnt  = HOLD_LEN;
    end
    if (hold_cnt > 0) begin
      out_tready <= 1'b0;
      hold_cnt--;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result, status %0d service %0d",
                 $time, out_tuser, out_tdata);
        errs++;
      end else begin
        want = pending_verdicts.pop_front();
        if (out_tuser !== want.st) begin
          $display("%0t: status expected %0d got %0d", $time, want.st, out_tuser);
          errs++;
        end
        if (out_tdata !== {{(OUT_DW - SVC_W){1'b0}}, want.svc}) begin
          $display("%0t: matched_service expected %0d got %0d", $time, want.svc, out_tdata);
          errs++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_MAX) begin
      $display("%0t: no item moved for %0d cycles", $time, quiet);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int unsigned i;
    int unsigned ph;
    dir_tab = '{
      '{'{MODE_LOOKUP, 10'd0, PROTO_TCP, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd80},
        1'b1, ST_NOMATCH, 10'd0},
      '{'{MODE_NOP, 10'd1023, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
          16'hFFFF}, 1'b1, ST_NOMATCH, 10'd0},
      '{'{MODE_APPEND, 10'd1023, PROTO_TCP, 16'd80, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0},
        1'b1, ST_APPENDED, 10'd0},
      '{'{MODE_LOOKUP, 10'd0, PROTO_TCP, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd80},
        1'b0, ST_NOMATCH, 10'd0},
      '{'{MODE_LOOKUP, 10'd0, PROTO_TCP, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd81},
        1'b0, ST_NOMATCH, 10'd0},
      '{'{MODE_APPEND, 10'd5, PROTO_UDP, 16'd1000, 16'd2000, 16'd0, 16'd0, 16'd0, 16'd0},
        1'b1, ST_APPENDED, 10'd0},
      '{'{MODE_LOOKUP, 10'd0, PROTO_UDP, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1000},
        1'b0, ST_NOMATCH, 10'd0},
      '{'{MODE_LOOKUP, 10'd0, PROTO_UDP, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd2000},
        1'b0, ST_NOMATCH, 10'd0},
      '{'{MODE_LOOKUP, 10'd0, PROTO_UDP, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd2001},
        1'b0, ST_NOMATCH, 10'd0},
      '{'{MODE_APPEND, 10'd7, PROTO_TCP, 16'd500, 16'd100, 16'd0, 16'hFFFF, 16'd0, 16'd0},
        1'b1, ST_APPENDED, 10'd0},
      '{'{MODE_LOOKUP, 10'd0, PROTO_TCP, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd300},
        1'b0, ST_NOMATCH, 10'd0},
      '{'{MODE_APPEND, 10'd9, PROTO_ICMP, 16'd8, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0},
        1'b1, ST_APPENDED, 10'd0},
      '{'{MODE_LOOKUP, 10'd0, PROTO_ICMP, 16'd0, 16'd0, 16'd0, 16'd0, 16'd8, 16'd0},
        1'b0, ST_NOMATCH, 10'd0},
      '{'{MODE_LOOKUP, 10'd0, PROTO_ICMP, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd8},
        1'b0, ST_NOMATCH, 10'd0},
      // port-less protocol stored with a destination range
      '{'{MODE_APPEND, 10'd0, 8'd255, 16'd10, 16'd20, 16'd0, 16'd0, 16'd0, 16'd0},
        1'b1, ST_APPENDED, 10'd0},
      '{'{MODE_LOOKUP, 10'd0, 8'd255, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF},
        1'b0, ST_NOMATCH, 10'd0},
      '{'{MODE_APPEND, 10'd3, 8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0},
        1'b1, ST_APPENDED, 10'd0},
      '{'{MODE_LOOKUP, 10'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        1'b0, ST_NOMATCH, 10'd0},
      '{'{MODE_APPEND, 10'd11, PROTO_TCP, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        1'b1, ST_APPENDED, 10'd0},
      '{'{MODE_LOOKUP, 10'd0, PROTO_TCP, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        1'b0, ST_NOMATCH, 10'd0},
      '{'{MODE_APPEND, 10'd12, PROTO_TCP, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd0},
        1'b1, ST_APPENDED, 10'd0},
      // earlier rule shadows the wide one
      '{'{MODE_LOOKUP, 10'd0, PROTO_TCP, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd80},
        1'b0, ST_NOMATCH, 10'd0},
      '{'{MODE_LOOKUP, 10'd0, PROTO_TCP, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1234, 16'd4321},
        1'b0, ST_NOMATCH, 10'd0},
      '{'{MODE_CLEAR, 10'd1023, PROTO_TCP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
          16'hFFFF}, 1'b1, ST_CLEARED, 10'd0},
      '{'{MODE_LOOKUP, 10'd0, PROTO_TCP, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd80},
        1'b1, ST_NOMATCH, 10'd0}
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < 25; i++)
      send_item(dir_tab[i].it, dir_tab[i].chk, '{dir_tab[i].st, dir_tab[i].svc});

    // fill the table, then one append past the end
    while (rule_cnt < N_RULES) send_item(rand_rule());
    send_item(rand_rule(), 1'b1, '{ST_FULL, '0});
    send_item(rand_lookup());

    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle = 18;
          recv_idle = 82;
          hold_req  = 1'b1;
        end
        1: begin
          send_idle = 82;
          recv_idle = 18;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      run_random(PHASE_ITEMS / 2);
      if (ph == 1) begin
        // sender pauses until the block has drained
        @(negedge clk);
        in_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge clk);
      end
      run_random(PHASE_ITEMS / 2);
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (N_RULES + 10) @(posedge clk);

    if (errs == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/spr_pkg.sv
hw/rtl/spr_cell.sv
hw/rtl/service_port_range_classifier.sv
verif/service_port_range_classifier_test.sv
